// ===== rtl/sqc_pkg.sv =====
// shared types, constants and helpers for the sensor sample quality classifier
package sqc_pkg;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int CSR_IDX_W = 3;

   // default limits and window lengths
   localparam logic [COUNT_W-1:0] SPIKE_COUNT_LIMIT_DEF = 8'd3;
   localparam logic [COUNT_W-1:0] ZERO_HIT_LIMIT_DEF    = 8'd2;
   localparam logic [COUNT_W-1:0] CAL_COUNT_LIMIT_DEF   = 8'd2;
   localparam logic [TIME_W-1:0]  SPIKE_WINDOW_MS_DEF   = 32'd1000;
   localparam logic [TIME_W-1:0]  STUCK_MS_DEF          = 32'd1000;
   localparam logic [TIME_W-1:0]  CAL_WINDOW_MS_DEF     = 32'd1000;

   // fixed zero window and calibration margin
   localparam logic [TIME_W-1:0]   ZERO_WINDOW_MS = 32'd1000;
   localparam logic [SAMPLE_W-1:0] CAL_MARGIN     = 24'd10;
   localparam logic [COUNT_W-1:0]  COUNT_MAX      = 8'hFF;

   // register reset values
   localparam logic [SAMPLE_W-1:0] DISCONNECT_BELOW_RST = 24'd10;
   localparam logic [SAMPLE_W-1:0] RAW_MIN_RST          = 24'd0;
   localparam logic [SAMPLE_W-1:0] RAW_MAX_RST          = 24'd1000000;
   localparam logic [SAMPLE_W-1:0] SPIKE_DELTA_RST      = 24'd500;
   localparam logic [SAMPLE_W-1:0] RAPID_DELTA_RST      = 24'd100;
   localparam logic [SAMPLE_W-1:0] STUCK_DELTA_RST      = 24'd2;
   localparam logic [SAMPLE_W-1:0] CAL_DRY_RST          = 24'd0;
   localparam logic [SAMPLE_W-1:0] CAL_WET_RST          = 24'd0;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISCONNECT_BELOW = 3'd0,
      CSR_RAW_MIN          = 3'd1,
      CSR_RAW_MAX          = 3'd2,
      CSR_SPIKE_DELTA      = 3'd3,
      CSR_RAPID_DELTA      = 3'd4,
      CSR_STUCK_DELTA      = 3'd5,
      CSR_CAL_DRY          = 3'd6,
      CSR_CAL_WET          = 3'd7
   } csr_index_type;

   // quality reason codes
   typedef enum logic [2:0] {
      REASON_OK           = 3'd0,
      REASON_DISCONNECTED = 3'd1,
      REASON_OUT_OF_RANGE = 3'd2,
      REASON_ZERO_HITS    = 3'd3,
      REASON_SPIKES       = 3'd4,
      REASON_RAPID        = 3'd5,
      REASON_STUCK        = 3'd6,
      REASON_CALIBRATE    = 3'd7
   } reason_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic       connected;
      reason_type reason;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] disconnect_below;
      logic [SAMPLE_W-1:0] raw_min;
      logic [SAMPLE_W-1:0] raw_max;
      logic [SAMPLE_W-1:0] spike_delta;
      logic [SAMPLE_W-1:0] rapid_delta;
      logic [SAMPLE_W-1:0] stuck_delta;
      logic [SAMPLE_W-1:0] cal_dry;
      logic [SAMPLE_W-1:0] cal_wet;
   } cfg_type;

   // history kept between items
   typedef struct packed {
      logic                has_last;
      logic [SAMPLE_W-1:0] last_sample;
      logic [COUNT_W-1:0]  zero_count;
      logic [TIME_W-1:0]   zero_start;
      logic                zero_active;
      logic [COUNT_W-1:0]  spike_hits;
      logic [TIME_W-1:0]   spike_start;
      logic                spike_active;
      logic [TIME_W-1:0]   stuck_start;
      logic                stuck_active;
      logic [COUNT_W-1:0]  below_hits;
      logic [COUNT_W-1:0]  above_hits;
      logic [TIME_W-1:0]   cal_start;
      logic                cal_active;
   } state_type;

   localparam state_type STATE_CLEAR = '0;

   // saturating counter step
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (c == COUNT_MAX) ? c : c + 8'd1;
   endfunction

endpackage

// ===== rtl/sqc_classify.sv =====
// combinational classification of one sample and the next history state
module sqc_classify #(
   parameter logic [7:0]  SPIKE_COUNT_LIMIT = sqc_pkg::SPIKE_COUNT_LIMIT_DEF,
   parameter logic [7:0]  ZERO_HIT_LIMIT    = sqc_pkg::ZERO_HIT_LIMIT_DEF,
   parameter logic [7:0]  CAL_COUNT_LIMIT   = sqc_pkg::CAL_COUNT_LIMIT_DEF,
   parameter logic [31:0] SPIKE_WINDOW_MS   = sqc_pkg::SPIKE_WINDOW_MS_DEF,
   parameter logic [31:0] STUCK_MS          = sqc_pkg::STUCK_MS_DEF,
   parameter logic [31:0] CAL_WINDOW_MS     = sqc_pkg::CAL_WINDOW_MS_DEF
) (
   input  sqc_pkg::req_type   item,
   input  sqc_pkg::cfg_type   cfg,
   input  sqc_pkg::state_type state_cur,
   output sqc_pkg::state_type state_nxt,
   output sqc_pkg::rsp_type   result
);

   logic [sqc_pkg::SAMPLE_W-1:0] s;
   logic [sqc_pkg::TIME_W-1:0]   now;
   logic [sqc_pkg::SAMPLE_W-1:0] delta;
   logic [sqc_pkg::SAMPLE_W-1:0] cal_lo;
   logic [sqc_pkg::SAMPLE_W-1:0] cal_hi;
   logic                         cal_en;
   logic                         cal_below;
   logic                         cal_above;

   assign s   = item.sample;
   assign now = item.now_ms;

   // step size against the last stored sample
   assign delta = (s > state_cur.last_sample) ? s - state_cur.last_sample
                                              : state_cur.last_sample - s;

   // calibration bounds with margin
   assign cal_lo    = (cfg.cal_dry < cfg.cal_wet) ? cfg.cal_dry : cfg.cal_wet;
   assign cal_hi    = (cfg.cal_dry > cfg.cal_wet) ? cfg.cal_dry : cfg.cal_wet;
   assign cal_en    = (cfg.cal_dry != '0) && (cfg.cal_wet != '0)
                      && ((cal_hi - cal_lo) >= sqc_pkg::CAL_MARGIN);
   assign cal_below = ({1'b0, s} + {1'b0, sqc_pkg::CAL_MARGIN}) < {1'b0, cal_lo};
   assign cal_above = {1'b0, s} > ({1'b0, cal_hi} + {1'b0, sqc_pkg::CAL_MARGIN});

   // priority checks, first flag wins
   always_comb begin
      sqc_pkg::state_type st;
      sqc_pkg::reason_type reason;
      logic done;

      st     = state_cur;
      reason = sqc_pkg::REASON_OK;
      done   = 1'b0;
      result.connected = 1'b1;

      if (s < cfg.disconnect_below) begin
         st = sqc_pkg::STATE_CLEAR;
         result.connected = 1'b0;
         reason = sqc_pkg::REASON_DISCONNECTED;
      end else if ((s < cfg.raw_min) || (s > cfg.raw_max)) begin
         reason = sqc_pkg::REASON_OUT_OF_RANGE;
      end else begin
         // window expiry
         if (st.zero_active && ((now - st.zero_start) > sqc_pkg::ZERO_WINDOW_MS)) begin
            st.zero_active = 1'b0;
            st.zero_count  = '0;
         end
         if (st.spike_active && ((now - st.spike_start) > SPIKE_WINDOW_MS)) begin
            st.spike_active = 1'b0;
            st.spike_hits   = '0;
         end
         if (st.cal_active && ((now - st.cal_start) > CAL_WINDOW_MS)) begin
            st.cal_active = 1'b0;
            st.below_hits = '0;
            st.above_hits = '0;
         end

         // zero samples
         if (s == '0) begin
            if (!st.zero_active) begin
               st.zero_active = 1'b1;
               st.zero_start  = now;
               st.zero_count  = '0;
            end
            st.zero_count = sqc_pkg::sat_inc(st.zero_count);
            if (st.zero_count >= ZERO_HIT_LIMIT) begin
               reason = sqc_pkg::REASON_ZERO_HITS;
               done   = 1'b1;
            end
         end

         // step size: spike, rapid, stuck
         if (!done) begin
            if (st.has_last) begin
               if (delta >= cfg.spike_delta) begin
                  if (!st.spike_active) begin
                     st.spike_active = 1'b1;
                     st.spike_start  = now;
                     st.spike_hits   = '0;
                  end
                  st.spike_hits = sqc_pkg::sat_inc(st.spike_hits);
                  if (st.spike_hits >= SPIKE_COUNT_LIMIT) begin
                     reason = sqc_pkg::REASON_SPIKES;
                     done   = 1'b1;
                  end
               end else if (delta >= cfg.rapid_delta) begin
                  reason = sqc_pkg::REASON_RAPID;
                  done   = 1'b1;
               end else if (delta <= cfg.stuck_delta) begin
                  if (!st.stuck_active) begin
                     st.stuck_active = 1'b1;
                     st.stuck_start  = now;
                  end else if ((now - st.stuck_start) >= STUCK_MS) begin
                     reason = sqc_pkg::REASON_STUCK;
                     done   = 1'b1;
                  end
               end else begin
                  st.stuck_active = 1'b0;
               end
            end else begin
               st.stuck_active = 1'b0;
            end
         end

         // calibration drift
         if (!done && cal_en) begin
            if (!st.cal_active) begin
               st.cal_active = 1'b1;
               st.cal_start  = now;
               st.below_hits = '0;
               st.above_hits = '0;
            end
            if (cal_below) begin
               st.below_hits = sqc_pkg::sat_inc(st.below_hits);
            end else if (cal_above) begin
               st.above_hits = sqc_pkg::sat_inc(st.above_hits);
            end
            if ((st.below_hits >= CAL_COUNT_LIMIT) || (st.above_hits >= CAL_COUNT_LIMIT)) begin
               reason = sqc_pkg::REASON_CALIBRATE;
            end
         end

         // every in-range connected sample is remembered
         st.has_last    = 1'b1;
         st.last_sample = s;
      end

      state_nxt     = st;
      result.reason = reason;
   end

endmodule

// ===== rtl/sensor_sample_quality_classifier.sv =====
// top level of the sensor sample quality classifier
//
//   channel | ports                              | direction | moves
//   --------+------------------------------------+-----------+--------------------------
//   req     | req_valid, req_ready, req_data     | in        | sample and timestamp item
//   rsp     | rsp_valid, rsp_ready, rsp_data     | out       | connected flag and reason
//   csr     | csr_write_en, csr_index, csr_wdata | in        | register write, no wait
//
// One item per cycle sustained while rsp_ready is high; each item goes from acceptance to result
// through the input register, then the result register. History updates at the result register edge,
// so the item loaded into the input register at that same edge already sees it.
// Reset is synchronous: config registers return to their defaults, valid flags and history clear.
// While rsp_ready is low the result holds and the input register still takes one item.
module sensor_sample_quality_classifier #(
   parameter logic [7:0]  SPIKE_COUNT_LIMIT = sqc_pkg::SPIKE_COUNT_LIMIT_DEF,
   parameter logic [7:0]  ZERO_HIT_LIMIT    = sqc_pkg::ZERO_HIT_LIMIT_DEF,
   parameter logic [7:0]  CAL_COUNT_LIMIT   = sqc_pkg::CAL_COUNT_LIMIT_DEF,
   parameter logic [31:0] SPIKE_WINDOW_MS   = sqc_pkg::SPIKE_WINDOW_MS_DEF,
   parameter logic [31:0] STUCK_MS          = sqc_pkg::STUCK_MS_DEF,
   parameter logic [31:0] CAL_WINDOW_MS     = sqc_pkg::CAL_WINDOW_MS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  sqc_pkg::req_type                        req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output sqc_pkg::rsp_type                        rsp_data,
   input  logic                                    csr_write_en,
   input  sqc_pkg::csr_index_type                  csr_index,
   input  logic [sqc_pkg::SAMPLE_W-1:0]            csr_wdata
);

   logic                in_valid_ff;
   sqc_pkg::req_type    in_data_ff;
   logic                out_valid_ff;
   sqc_pkg::rsp_type    out_data_ff;
   sqc_pkg::cfg_type    cfg_ff;
   sqc_pkg::cfg_type    cfg_in;
   sqc_pkg::state_type  state_ff;
   sqc_pkg::state_type  state_in;
   sqc_pkg::rsp_type    result;
   logic                advance;

   // stage handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            sqc_pkg::CSR_DISCONNECT_BELOW: cfg_in.disconnect_below = csr_wdata;
            sqc_pkg::CSR_RAW_MIN:          cfg_in.raw_min          = csr_wdata;
            sqc_pkg::CSR_RAW_MAX:          cfg_in.raw_max          = csr_wdata;
            sqc_pkg::CSR_SPIKE_DELTA:      cfg_in.spike_delta      = csr_wdata;
            sqc_pkg::CSR_RAPID_DELTA:      cfg_in.rapid_delta      = csr_wdata;
            sqc_pkg::CSR_STUCK_DELTA:      cfg_in.stuck_delta      = csr_wdata;
            sqc_pkg::CSR_CAL_DRY:          cfg_in.cal_dry          = csr_wdata;
            sqc_pkg::CSR_CAL_WET:          cfg_in.cal_wet          = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   // classification logic
   sqc_classify #(
      .SPIKE_COUNT_LIMIT (SPIKE_COUNT_LIMIT),
      .ZERO_HIT_LIMIT    (ZERO_HIT_LIMIT),
      .CAL_COUNT_LIMIT   (CAL_COUNT_LIMIT),
      .SPIKE_WINDOW_MS   (SPIKE_WINDOW_MS),
      .STUCK_MS          (STUCK_MS),
      .CAL_WINDOW_MS     (CAL_WINDOW_MS)
   ) u_classify (
      .item      (in_data_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   // control, config and history
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= sqc_pkg::STATE_CLEAR;
         cfg_ff.disconnect_below <= sqc_pkg::DISCONNECT_BELOW_RST;
         cfg_ff.raw_min          <= sqc_pkg::RAW_MIN_RST;
         cfg_ff.raw_max          <= sqc_pkg::RAW_MAX_RST;
         cfg_ff.spike_delta      <= sqc_pkg::SPIKE_DELTA_RST;
         cfg_ff.rapid_delta      <= sqc_pkg::RAPID_DELTA_RST;
         cfg_ff.stuck_delta      <= sqc_pkg::STUCK_DELTA_RST;
         cfg_ff.cal_dry          <= sqc_pkg::CAL_DRY_RST;
         cfg_ff.cal_wet          <= sqc_pkg::CAL_WET_RST;
      end else begin
         cfg_ff <= cfg_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

endmodule
